// ===== rtl/pfm_pkg.sv =====
// shared types and constants of the phase and frequency meter
package pfm_pkg;

    localparam int TICK_W   = 16;
    localparam int US_W     = 16;
    localparam int DELAY_W  = 17;
    localparam int SUM_W    = 19;
    localparam int NUM_W    = 28;
    localparam int DIVR_W   = 15;
    localparam int FREQ_W   = 20;
    localparam int PHASE_W  = 16;
    localparam int STEP_W   = 5;

    // x / 3 == (x * 43691) >> 17 for every 16-bit x
    localparam logic [16:0]       DIV3_RECIP   = 17'd43691;
    localparam int                DIV3_SHIFT   = 17;
    localparam logic [11:0]       FULL_TURN    = 12'd3600;
    localparam logic [FREQ_W-1:0] ONE_MILLION  = 20'd1000000;
    localparam logic [US_W-1:0]   GLITCH_RESET = 16'd100;

    localparam logic [STEP_W-1:0] PHASE_STEPS  = 5'd28;
    localparam logic [STEP_W-1:0] FREQ_STEPS   = 5'd20;

    localparam logic signed [PHASE_W-1:0] PHASE_MAX = 16'sh7FFF;
    localparam logic signed [PHASE_W-1:0] PHASE_MIN = 16'sh8000;

    typedef struct packed {
        logic load;      // capture raw ticks
        logic conv;      // ticks to microseconds
        logic sel;       // glitch select and phase numerator sign
        logic mul;       // scale numerator by a full turn
        logic div_phase; // start numerator / period
        logic div_freq;  // start one million / period
        logic fin;       // load the output register
    } pfm_cmd_t;

    typedef struct packed {
        logic period_zero;
        logic div_busy;
        logic out_free;
    } pfm_status_t;

endpackage

// ===== rtl/phase_frequency_meter.sv =====
// top level of the phase and frequency meter
//
// each input item is one measurement (period and zero-crossing delay in timer
// ticks, three ticks per microsecond) and yields exactly one result item.
// the period in microseconds is checked against glitch_min_period_us; a short
// period falls back to the last accepted one. a nonzero period gives the
// frequency in hertz and the phase in tenths of a degree, truncated toward zero
// and saturated to 16 bits; a zero period gives an item with m_tuser low, zero
// frequency and phase. next_reference follows the phase sign and should steer
// the edge order of the capture front end. an item passes through conversion,
// select, scale and divider start, then one bit per cycle of a single shared
// divider: 28 steps for the phase and 20 for the frequency, and then the output
// register is loaded; both divisions are skipped when the period is zero. the
// next item is taken only after the result is loaded, and a result still
// waiting in the output register holds the new one back.
// s_tready is high only between items; a finished result waits in the output
// register while the next item is taken.
// configuration is written through cfg_valid/cfg_data, always ready, and must
// only be written while no item is in flight. reset is synchronous, active low.
module phase_frequency_meter import pfm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] period_ticks, [31:16] delay_ticks

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [19:0] frequency_hz, [35:20] phase_tenths,
                                   // [36] next_reference, [39:37] zero
    output logic        m_tuser,   // [0] result_valid

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // glitch_min_period_us
);

    pfm_cmd_t    cmd;
    pfm_status_t status;

    logic              res_valid;
    logic [FREQ_W-1:0] freq_hz;
    logic [PHASE_W-1:0] phase_tenths;
    logic              next_ref;

    // register writes are taken in any cycle
    assign cfg_ready = 1'b1;

    pfm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfm_dpath u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .period_ticks       (s_tdata[15:0]),
        .delay_ticks        (s_tdata[31:16]),
        .cfg_we             (cfg_valid),
        .cfg_data           (cfg_data),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .out_result_valid   (res_valid),
        .out_frequency_hz   (freq_hz),
        .out_phase_tenths   (phase_tenths),
        .out_next_reference (next_ref)
    );

    // pack result item, lowest field first
    assign m_tdata = {3'b000, next_ref, phase_tenths, freq_hz};
    assign m_tuser = res_valid;

endmodule

// ===== rtl/pfm_div.sv =====
// restoring divider, one quotient bit per cycle
module pfm_div import pfm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  dividend,
    input  logic [STEP_W-1:0] steps,
    input  logic [DIVR_W-1:0] divisor,
    output logic              busy,
    output logic [NUM_W-1:0]  quotient
);

    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]  quot_reg, quot_next;
    logic [DIVR_W-1:0] divr_reg;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [DIVR_W:0]   rem_sh;
    logic [DIVR_W+1:0] diff;

    assign rem_sh = {rem_reg, quot_reg[NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, divr_reg};

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quot_next = dividend;
            cnt_next  = steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DIVR_W+1]) begin
                rem_next  = diff[DIVR_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[DIVR_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != 5'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start) begin
            divr_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

// ===== rtl/pfm_dpath.sv =====
// datapath: conversion, glitch filter, phase numerator, shared divider, output register
module pfm_dpath import pfm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  pfm_cmd_t            cmd,
    output pfm_status_t         status,
    input  logic [TICK_W-1:0]   period_ticks,
    input  logic [TICK_W-1:0]   delay_ticks,
    input  logic                cfg_we,
    input  logic [US_W-1:0]     cfg_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_result_valid,
    output logic [FREQ_W-1:0]   out_frequency_hz,
    output logic [PHASE_W-1:0]  out_phase_tenths,
    output logic                out_next_reference
);

    logic [US_W-1:0]          glitch_reg;
    logic [US_W-1:0]          last_good_reg;
    logic                     ref_reg;
    logic [TICK_W-1:0]        pt_reg, dt_reg;
    logic [US_W-1:0]          per_us_reg;
    logic [DELAY_W-1:0]       del_us_reg;
    logic [DIVR_W-1:0]        per_reg;
    logic                     per_zero_reg;
    logic [US_W-1:0]          mag_reg;
    logic                     neg_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [PHASE_W-1:0]       phase_reg;

    logic                     oval_reg, ores_reg, oref_reg;
    logic [FREQ_W-1:0]        ofreq_reg;
    logic [PHASE_W-1:0]       ophase_reg;

    logic [TICK_W+16:0]       pt_prod, dt_prod;
    logic [US_W-1:0]          per_sel;
    logic [DELAY_W:0]         twice_d;
    logic signed [SUM_W-1:0]  s_d, s_p, s_val;
    logic [SUM_W-1:0]         s_abs;
    logic [NUM_W-1:0]         num_prod;

    logic                     div_start;
    logic [NUM_W-1:0]         div_dividend;
    logic [STEP_W-1:0]        div_steps;
    logic                     div_busy;
    logic [NUM_W-1:0]         div_q;
    logic signed [PHASE_W-1:0] phase_sat;

    // constant reciprocal for the divide by three
    assign pt_prod = {17'd0, pt_reg} * {16'd0, DIV3_RECIP};
    assign dt_prod = {17'd0, dt_reg} * {16'd0, DIV3_RECIP};

    assign per_sel = (per_us_reg < glitch_reg) ? last_good_reg : per_us_reg;
    assign twice_d = {del_us_reg, 1'b0};
    assign s_d     = signed'({2'b00, del_us_reg});
    assign s_p     = signed'({3'b000, per_sel});

    // signed phase numerator before the full-turn scale, wrap chosen by edge order
    always_comb begin
        if (ref_reg) begin
            s_val = (twice_d > {2'b00, per_sel}) ? (s_d - s_p) : s_d;
        end else begin
            s_val = (twice_d >= {2'b00, per_sel}) ? (s_p - s_d) : -s_d;
        end
        s_abs = s_val[SUM_W-1] ? unsigned'(-s_val) : unsigned'(s_val);
    end

    assign num_prod = {12'd0, mag_reg} * {16'd0, FULL_TURN};

    assign div_start    = cmd.div_phase | cmd.div_freq;
    assign div_dividend = cmd.div_freq ? {ONE_MILLION, 8'd0} : num_reg;
    assign div_steps    = cmd.div_freq ? FREQ_STEPS : PHASE_STEPS;

    pfm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .steps    (div_steps),
        .divisor  (per_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // truncated toward zero, then saturated
    always_comb begin
        if (neg_reg) begin
            if (div_q > 28'd32768) begin
                phase_sat = PHASE_MIN;
            end else begin
                phase_sat = -signed'(div_q[PHASE_W-1:0]);
            end
        end else begin
            if (div_q > 28'd32767) begin
                phase_sat = PHASE_MAX;
            end else begin
                phase_sat = signed'(div_q[PHASE_W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glitch_reg    <= GLITCH_RESET;
            last_good_reg <= '0;
            ref_reg       <= 1'b0;
            oval_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                glitch_reg <= cfg_data;
            end
            if (cmd.sel && !(per_us_reg < glitch_reg)) begin
                last_good_reg <= per_us_reg;
            end
            if (cmd.fin && !per_zero_reg) begin
                ref_reg <= ~neg_reg;
            end
            if (cmd.fin) begin
                oval_reg <= 1'b1;
            end else if (out_ready) begin
                oval_reg <= 1'b0;
            end
        end

        if (cmd.load) begin
            pt_reg <= period_ticks;
            dt_reg <= delay_ticks;
        end
        if (cmd.conv) begin
            per_us_reg <= pt_prod[DIV3_SHIFT +: US_W];
            del_us_reg <= {dt_prod[DIV3_SHIFT +: US_W], 1'b0};
        end
        if (cmd.sel) begin
            per_reg      <= per_sel[DIVR_W-1:0];
            per_zero_reg <= (per_sel == '0);
            mag_reg      <= s_abs[US_W-1:0];
            neg_reg      <= s_val[SUM_W-1];
        end
        if (cmd.mul) begin
            num_reg <= num_prod;
        end
        // phase quotient is held while the frequency division runs
        if (cmd.div_freq) begin
            phase_reg <= phase_sat;
        end
        if (cmd.fin) begin
            if (per_zero_reg) begin
                ores_reg   <= 1'b0;
                ofreq_reg  <= '0;
                ophase_reg <= '0;
                oref_reg   <= ref_reg;
            end else begin
                ores_reg   <= 1'b1;
                ofreq_reg  <= div_q[FREQ_W-1:0];
                ophase_reg <= phase_reg;
                oref_reg   <= ~neg_reg;
            end
        end
    end

    assign status.period_zero = per_zero_reg;
    assign status.div_busy    = div_busy;
    assign status.out_free    = !oval_reg || out_ready;

    assign out_valid          = oval_reg;
    assign out_result_valid   = ores_reg;
    assign out_frequency_hz   = ofreq_reg;
    assign out_phase_tenths   = ophase_reg;
    assign out_next_reference = oref_reg;

endmodule

// ===== rtl/pfm_ctrl.sv =====
// controller state machine sequencing one measurement through the datapath
module pfm_ctrl import pfm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  pfm_status_t status,
    output pfm_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_SEL,
        ST_MUL,
        ST_PH_START,
        ST_PH_WAIT,
        ST_FR_START,
        ST_FR_WAIT,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.conv   = 1'b1;
                state_next = ST_SEL;
            end
            ST_SEL: begin
                cmd.sel    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = status.period_zero ? ST_FIN : ST_PH_START;
            end
            ST_PH_START: begin
                cmd.div_phase = 1'b1;
                state_next    = ST_PH_WAIT;
            end
            ST_PH_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_FR_START;
                end
            end
            ST_FR_START: begin
                cmd.div_freq = 1'b1;
                state_next   = ST_FR_WAIT;
            end
            ST_FR_WAIT: begin
                if (!status.div_busy) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
